// ===== src/sps_pkg.sv =====
// Shared types, constants and helper functions for the sprite pixel serializer.
// Used by sps_channel, sps_priority and the top level sprite_pixel_serializer.
package sps_pkg;

  localparam int SPRITE_COUNT = 8;
  localparam int MAX_WORDS    = 4;
  localparam int CHAN_SLOTS   = 8;
  localparam int PAIR_COUNT   = 4;
  localparam int WORD_IDX_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  localparam logic [4:0] RUN_LEN = 5'd16;
  localparam logic [2:0] FETCH_MAX = 3'(MAX_WORDS);

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_POS  = 2'd1,
    REQ_DATA = 2'd2,
    REQ_LINE = 2'd3
  } req_type_t;

  localparam logic REG_COLOR_BANKS = 1'b0;
  localparam logic REG_COLLIDE_EN  = 1'b1;

  typedef struct packed {
    logic        tick;
    logic        line_start;
    logic        pos_wr;
    logic        data_wr;
    logic [2:0]  sprite_num;
    logic [1:0]  word_slot;
    logic [8:0]  pixel_x;
    logic [15:0] pos_word;
    logic [15:0] ctl_word;
    logic [15:0] data_a;
    logic [15:0] data_b;
  } sps_req_t;

  // Interleave two data words: bit 2i from lo[i], bit 2i+1 from hi[i].
  function automatic logic [31:0] weave(input logic [15:0] lo, input logic [15:0] hi);
    logic [31:0] r;
    for (int i = 0; i < 16; i++) begin
      r[2*i]   = lo[i];
      r[2*i+1] = hi[i];
    end
    return r;
  endfunction

  // Collision register bits 14:9 for a pair-present mask.
  function automatic logic [5:0] collide_bits(input logic [3:0] present);
    logic [5:0] r;
    case (present)
      4'd3:    r = 6'h01;
      4'd5:    r = 6'h02;
      4'd6:    r = 6'h08;
      4'd7:    r = 6'h0b;
      4'd9:    r = 6'h04;
      4'd10:   r = 6'h10;
      4'd11:   r = 6'h15;
      4'd12:   r = 6'h20;
      4'd13:   r = 6'h26;
      4'd14:   r = 6'h38;
      4'd15:   r = 6'h3f;
      default: r = 6'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== src/sps_channel.sv =====
// One sprite channel: position/control, data word store, run counter and shifter.
// Depends on sps_pkg.
module sps_channel
  import sps_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  sps_req_t       req,
  input  logic [2:0]     chan_id,
  input  logic           enable,
  input  logic [2:0]     words_fetched,
  output logic [1:0]     pixel,
  output logic           attach
);

  logic [15:0] pos;
  logic [15:0] ctl;
  logic [15:0] store_a [MAX_WORDS];
  logic [15:0] store_b [MAX_WORDS];
  logic [4:0]  run;
  logic [31:0] sr;
  logic [2:0]  used;
  logic [4:0]  run_next;
  logic [31:0] sr_next;
  logic [2:0]  used_next;
  logic [4:0]  run_cur;
  logic [31:0] sr_cur;
  logic [2:0]  used_cur;
  logic [8:0]  hstart;
  logic        sel;

  assign hstart = {pos[7:0], ctl[0]};
  assign sel    = (req.sprite_num == chan_id);
  assign attach = ctl[7];

  always_comb begin
    run_cur   = run;
    sr_cur    = sr;
    used_cur  = used;
    pixel     = 2'b00;
    run_next  = run;
    sr_next   = sr;
    used_next = used;
    if (req.tick && enable) begin
      if (run == 5'd0 && hstart == req.pixel_x) begin
        sr_cur   = weave(store_a[0], store_b[0]);
        run_cur  = RUN_LEN;
        used_cur = 3'd1;
      end
      if (run_cur != 5'd0) begin
        pixel     = sr_cur[31:30];
        run_next  = run_cur - 5'd1;
        sr_next   = {sr_cur[29:0], 2'b00};
        used_next = used_cur;
        if (run_next == 5'd0 && used_cur < words_fetched) begin
          sr_next   = weave(store_a[used_cur[WORD_IDX_W-1:0]],
                            store_b[used_cur[WORD_IDX_W-1:0]]);
          run_next  = RUN_LEN;
          used_next = used_cur + 3'd1;
        end
      end
    end
    if (req.line_start) begin
      run_next  = 5'd0;
      used_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 5'd0;
      sr   <= 32'd0;
      used <= 3'd0;
      pos  <= 16'd0;
      ctl  <= 16'd0;
      for (int i = 0; i < MAX_WORDS; i++) begin
        store_a[i] <= 16'd0;
        store_b[i] <= 16'd0;
      end
    end else begin
      run  <= run_next;
      sr   <= sr_next;
      used <= used_next;
      if (req.pos_wr && sel) begin
        pos <= req.pos_word;
        ctl <= req.ctl_word;
      end
      if (req.data_wr && sel && int'(req.word_slot) < MAX_WORDS) begin
        store_a[req.word_slot[WORD_IDX_W-1:0]] <= req.data_a;
        store_b[req.word_slot[WORD_IDX_W-1:0]] <= req.data_b;
      end
    end
  end

endmodule

// ===== src/sps_priority.sv =====
// Sprite priority and collision logic: picks the topmost pair's color and bank.
// Depends on sps_pkg.
module sps_priority
  import sps_pkg::*;
(
  input  logic [2*CHAN_SLOTS-1:0] pixels,
  input  logic [PAIR_COUNT-1:0]   attach,
  input  logic [7:0]              color_banks,
  input  logic [3:0]              collide_en,
  output logic [13:0]             sprite_word,
  output logic [5:0]              sprite_collisions
);

  logic [3:0] present;
  logic [3:0] nib;
  logic       found;

  always_comb begin
    for (int p = 0; p < PAIR_COUNT; p++) begin
      present[p] = (|pixels[4*p +: 2]) | (collide_en[p] & (|pixels[4*p+2 +: 2]));
    end
  end

  assign sprite_collisions = collide_bits(present);

  always_comb begin
    sprite_word = 14'd0;
    found       = 1'b0;
    nib         = 4'd0;
    for (int p = 0; p < PAIR_COUNT; p++) begin
      nib = pixels[4*p +: 4];
      if (!found && nib != 4'd0) begin
        found = 1'b1;
        if (attach[p]) begin
          sprite_word = {2'(p), present, color_banks[3:0], nib};
        end else if (nib[1:0] != 2'b00) begin
          sprite_word = {2'(p), present, color_banks[7:4], 2'(p), nib[1:0]};
        end else begin
          sprite_word = {2'(p), present, color_banks[3:0], 2'(p), nib[3:2]};
        end
      end
    end
  end

endmodule

// ===== src/sprite_pixel_serializer.sv =====
// Sprite pixel serializer top level: request register, channels, result register.
// Depends on sps_pkg, sps_channel and sps_priority.
//
// Eight sprite channels serialized one low-res pixel per tick. Requests enter on the
// s_ stream (tuser selects pixel tick, position/control write, data word write or line
// start); only a pixel tick returns a result on the m_ stream, from the result register.
// The block takes one request per cycle: each request is worked combinationally between
// the request register and the result register, and the request register stalls only
// while a tick result waits in a full, stalled result register.
// Color banks and odd-sprite collision enables are set through the APB port.
module sprite_pixel_serializer
  import sps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sprite_num[2:0], word_slot[4:3], pixel_x[13:5], pos_word[29:14], ctl_word[45:30],
  // data_a[61:46], data_b[77:62], enable_mask[85:78], fetched_words[88:86]
  input  logic [95:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // sprite_word[13:0], sprite_collisions[19:14]
  output logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_valid;
  req_type_t   in_type;
  logic [88:0] in_data;
  logic        fire;
  logic        is_tick;
  sps_req_t    req;

  logic [7:0]  color_banks;
  logic [3:0]  collide_en;
  logic [7:0]  comp_en;
  logic [2:0]  words_fetched;
  logic [2:0]  fetch_sat;

  logic [2*CHAN_SLOTS-1:0] pixels;
  logic [CHAN_SLOTS-1:0]   attach_all;
  logic [PAIR_COUNT-1:0]   attach;
  logic [13:0]             word_c;
  logic [5:0]              coll_c;

  assign is_tick  = (in_type == REQ_TICK);
  assign fire     = in_valid && (!is_tick || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= req_type_t'(s_tuser);
      in_data <= s_tdata[88:0];
    end
  end

  always_comb begin
    req.tick       = fire && in_type == REQ_TICK;
    req.pos_wr     = fire && in_type == REQ_POS;
    req.data_wr    = fire && in_type == REQ_DATA;
    req.line_start = fire && in_type == REQ_LINE;
    req.sprite_num = in_data[2:0];
    req.word_slot  = in_data[4:3];
    req.pixel_x    = in_data[13:5];
    req.pos_word   = in_data[29:14];
    req.ctl_word   = in_data[45:30];
    req.data_a     = in_data[61:46];
    req.data_b     = in_data[77:62];
  end

  assign fetch_sat = (in_data[88:86] > FETCH_MAX) ? FETCH_MAX : in_data[88:86];

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_en       <= 8'd0;
      words_fetched <= 3'd1;
    end else if (req.line_start) begin
      comp_en       <= in_data[85:78];
      words_fetched <= fetch_sat;
    end
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_banks <= 8'd0;
      collide_en  <= 4'd0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_COLOR_BANKS) begin
        color_banks <= pwdata[7:0];
      end else begin
        collide_en <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COLOR_BANKS: prdata = {24'd0, color_banks};
      REG_COLLIDE_EN:  prdata = {28'd0, collide_en};
      default:         prdata = 32'd0;
    endcase
  end

  for (genvar g = 0; g < CHAN_SLOTS; g++) begin : g_chan
    if (g < SPRITE_COUNT) begin : g_on
      sps_channel u_chan (
        .clk           (clk),
        .rst           (rst),
        .req           (req),
        .chan_id       (3'(g)),
        .enable        (comp_en[g]),
        .words_fetched (words_fetched),
        .pixel         (pixels[2*g +: 2]),
        .attach        (attach_all[g])
      );
    end else begin : g_off
      assign pixels[2*g +: 2] = 2'b00;
      assign attach_all[g]    = 1'b0;
    end
  end

  for (genvar p = 0; p < PAIR_COUNT; p++) begin : g_pair
    assign attach[p] = attach_all[2*p+1];
  end

  sps_priority u_prio (
    .pixels            (pixels),
    .attach            (attach),
    .color_banks       (color_banks),
    .collide_en        (collide_en),
    .sprite_word       (word_c),
    .sprite_collisions (coll_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (req.tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.tick) begin
      m_tdata <= {4'd0, coll_c, word_c};
    end
  end

`ifndef SYNTH
  a_no_coll_without_pixel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13:0] == 14'd0 |-> m_tdata[19:14] == 6'd0)
    else $error("collision bits without a sprite pixel");

  a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && is_tick && m_tvalid && !m_tready)
    else $error("request side stalled without a blocked tick result");

  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    req.tick |=> m_tvalid)
    else $error("pixel tick produced no result");
`endif

endmodule
